// ===== hw/rtl/cds_pkg.sv =====
`timescale 1ns / 1ps

package cds_pkg;

    localparam int DAY_W  = 5;
    localparam int MON_W  = 4;
    localparam int YEAR_W = 14;
    localparam int CNT_W  = 16;
    localparam int DIST_W = 22;
    localparam int NUM_W  = 23;
    localparam int DOY_W  = 9;

    localparam logic [YEAR_W-1:0] MAX_YEAR = 14'd9999;
    localparam logic [YEAR_W-1:0] MIN_YEAR = 14'd1;
    localparam logic [MON_W-1:0]  MONTH_JAN = 4'd1;
    localparam logic [MON_W-1:0]  MONTH_FEB = 4'd2;
    localparam logic [MON_W-1:0]  MONTH_DEC = 4'd12;
    localparam logic [DAY_W-1:0]  DAY_FIRST = 5'd1;
    localparam logic [DAY_W-1:0]  DAY_LAST_DEC = 5'd31;
    localparam logic [DOY_W-1:0]  YEAR_LEN = 9'd365;

    // Division by 100 is a multiplication by 5243 / 2^19. For years below
    // 16384 the quotient is exact, and the low 19 product bits stay below
    // 5243 exactly when the year is a multiple of 100.
    localparam int RECIP_W = 13;
    localparam int PROD_W  = YEAR_W + RECIP_W;
    localparam int FRAC_W  = 19;
    localparam int QUOT_W  = PROD_W - FRAC_W;
    localparam logic [RECIP_W-1:0] RECIP100 = 13'd5243;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_ADVANCE = 2'd1,
        CMD_RETREAT = 2'd2,
        CMD_COMPARE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REL_EQUAL   = 2'd0,
        REL_LATER   = 2'd1,
        REL_EARLIER = 2'd2
    } relation_t;

    // Packed year, month, day: comparing two of these as numbers orders
    // them by year, then month, then day.
    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [MON_W-1:0]  month;
        logic [DAY_W-1:0]  day;
    } date_t;

    // Leap test from the year and its product with the reciprocal of 100.
    function automatic logic leap_from_prod(input logic [YEAR_W-1:0] y,
                                            input logic [PROD_W-1:0] prod);
        logic not_century;
        logic quad_century;
        not_century  = prod[FRAC_W-1:0] >= FRAC_W'(RECIP100);
        quad_century = prod[FRAC_W+1:FRAC_W] == 2'b00;
        return (y[1:0] == 2'b00) && (not_century || quad_century);
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Days in the months before month m of a common year.
    function automatic logic [DOY_W-1:0] cum_days(input logic [MON_W-1:0] m);
        logic [DOY_W-1:0] days;
        case (m)
            4'd1:    days = 9'd0;
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

    function automatic logic date_ok(input date_t dt, input logic leap);
        return (dt.year >= MIN_YEAR) && (dt.year <= MAX_YEAR) &&
               (dt.day != 5'd0) && (dt.day <= month_len(dt.month, leap));
    endfunction

endpackage

// ===== hw/rtl/calendar_date_stepper.sv =====
`timescale 1ns / 1ps
// Load: done pulses in the cycle after the accept edge. Compare: done pulses
// after states CMPA to CMPD. Advance and retreat: each STEP crosses a month or
// skips a whole year, with LEAP after each change of year. For compares and for
// steps from a valid stored date, busy stays high from the accept edge until the
// cycle in which done pulses. One beat is in flight at a time, and the receiver
// cannot stall it. Reset (asynchronous, active low) sets the date to 1 January 2000.
module calendar_date_stepper import cds_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        command,
    input  logic [DAY_W-1:0]  day_in,
    input  logic [MON_W-1:0]  month_in,
    input  logic [YEAR_W-1:0] year_in,
    input  logic [CNT_W-1:0]  step_count,
    output logic              done,
    output logic [DAY_W-1:0]  day_out,
    output logic [MON_W-1:0]  month_out,
    output logic [YEAR_W-1:0] year_out,
    output logic              date_valid,
    output logic [1:0]        relation,
    output logic [DIST_W-1:0] days_between,
    output logic              limit_hit
);

    // The sequencer. STEP walks the stored date a month (or a whole year)
    // per cycle, but after a year change LEAP refreshes the cached leap flag;
    // the four CMP states feed both dates through the day-number pipeline.
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_STEP = 7'b0000010,
        S_LEAP = 7'b0000100,
        S_CMPA = 7'b0001000,
        S_CMPB = 7'b0010000,
        S_CMPC = 7'b0100000,
        S_CMPD = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic              done_reg, done_next;
    logic [DAY_W-1:0]  cur_day_reg, cur_day_next;
    logic [MON_W-1:0]  cur_month_reg, cur_month_next;
    logic [YEAR_W-1:0] cur_year_reg, cur_year_next;
    logic              leap_reg, leap_next;
    cmd_t              cmd_reg, cmd_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    date_t             gdate_reg, gdate_next;
    logic              gvalid_reg, gvalid_next;
    logic [NUM_W-1:0]  na_reg, na_next;
    relation_t         relation_reg, relation_next;
    logic [DIST_W-1:0] between_reg, between_next;
    logic              limit_reg, limit_next;

    date_t             cur_date;
    date_t             in_date;
    logic              cur_valid;
    logic [YEAR_W-1:0] year_sel;
    logic [PROD_W-1:0] year_prod;
    logic              year_leap;
    logic [DAY_W-1:0]  mlen;
    logic [DAY_W-1:0]  prev_mlen;
    logic [CNT_W-1:0]  left_cnt;
    logic [CNT_W-1:0]  day_cnt;
    logic [CNT_W-1:0]  ylen;
    date_t             dn_date;
    logic [NUM_W-1:0]  dn_number;
    logic [NUM_W-1:0]  day_gap;

    assign cur_date  = '{year: cur_year_reg, month: cur_month_reg, day: cur_day_reg};
    assign in_date   = '{year: year_in, month: month_in, day: day_in};
    assign cur_valid = date_ok(cur_date, leap_reg);

    // One leap-test multiplier, shared: it looks at the incoming year while
    // idle and at the stored year while the stepper is running.
    assign year_sel  = (state_reg == S_IDLE) ? year_in : cur_year_reg;
    assign year_prod = PROD_W'(year_sel) * PROD_W'(RECIP100);
    assign year_leap = leap_from_prod(year_sel, year_prod);

    assign mlen      = month_len(cur_month_reg, leap_reg);
    assign prev_mlen = month_len(cur_month_reg - 1'b1, leap_reg);
    assign left_cnt  = CNT_W'(mlen - cur_day_reg);
    assign day_cnt   = CNT_W'(cur_day_reg);
    assign ylen      = CNT_W'(YEAR_LEN) + CNT_W'(leap_reg);

    // The stored date enters the pipeline first, the given date in the cycle after.
    assign dn_date = (state_reg == S_CMPA) ? cur_date : gdate_reg;

    cds_daynum u_daynum
    (
        .clk    (clk),
        .date   (dn_date),
        .number (dn_number)
    );

    assign day_gap = (na_reg >= dn_number) ? (na_reg - dn_number) : (dn_number - na_reg);

    always_comb
    begin
        state_next     = state_reg;
        done_next      = 1'b0;
        cur_day_next   = cur_day_reg;
        cur_month_next = cur_month_reg;
        cur_year_next  = cur_year_reg;
        leap_next      = leap_reg;
        cmd_next       = cmd_reg;
        rem_next       = rem_reg;
        gdate_next     = gdate_reg;
        gvalid_next    = gvalid_reg;
        na_next        = na_reg;
        relation_next  = relation_reg;
        between_next   = between_reg;
        limit_next     = limit_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next      = cmd_t'(command);
                    rem_next      = step_count;
                    gdate_next    = in_date;
                    gvalid_next   = date_ok(in_date, year_leap);
                    relation_next = REL_EQUAL;
                    between_next  = '0;
                    limit_next    = 1'b0;
                    case (cmd_t'(command))
                        CMD_LOAD:
                        begin
                            cur_day_next   = day_in;
                            cur_month_next = month_in;
                            cur_year_next  = year_in;
                            leap_next      = year_leap;
                            done_next      = 1'b1;
                        end
                        CMD_ADVANCE, CMD_RETREAT:
                        begin
                            // An invalid stored date is left as it is.
                            if (cur_valid)
                            begin
                                state_next = S_STEP;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        CMD_COMPARE:
                        begin
                            if (cur_date == in_date)
                            begin
                                relation_next = REL_EQUAL;
                            end
                            else if (cur_date > in_date)
                            begin
                                relation_next = REL_LATER;
                            end
                            else
                            begin
                                relation_next = REL_EARLIER;
                            end
                            state_next = S_CMPA;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            S_STEP:
            begin
                if (cmd_reg == CMD_ADVANCE)
                begin
                    if (rem_reg == '0)
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (cur_month_reg == MONTH_JAN && cur_day_reg == DAY_FIRST &&
                             cur_year_reg < MAX_YEAR && rem_reg >= ylen)
                    begin
                        // From 1 January a whole year moves in one step.
                        rem_next      = rem_reg - ylen;
                        cur_year_next = cur_year_reg + 1'b1;
                        state_next    = S_LEAP;
                    end
                    else if (rem_reg <= left_cnt)
                    begin
                        cur_day_next = cur_day_reg + rem_reg[DAY_W-1:0];
                        rem_next     = '0;
                        done_next    = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else if (cur_month_reg == MONTH_DEC)
                    begin
                        if (cur_year_reg == MAX_YEAR)
                        begin
                            // Past the last representable day: clamp there.
                            cur_day_next = mlen;
                            limit_next   = 1'b1;
                            done_next    = 1'b1;
                            state_next   = S_IDLE;
                        end
                        else
                        begin
                            rem_next       = rem_reg - left_cnt - 1'b1;
                            cur_day_next   = DAY_FIRST;
                            cur_month_next = MONTH_JAN;
                            cur_year_next  = cur_year_reg + 1'b1;
                            state_next     = S_LEAP;
                        end
                    end
                    else
                    begin
                        rem_next       = rem_reg - left_cnt - 1'b1;
                        cur_day_next   = DAY_FIRST;
                        cur_month_next = cur_month_reg + 1'b1;
                    end
                end
                else
                begin
                    if (rem_reg < day_cnt)
                    begin
                        cur_day_next = cur_day_reg - rem_reg[DAY_W-1:0];
                        rem_next     = '0;
                        done_next    = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else if (cur_month_reg == MONTH_DEC && cur_day_reg == DAY_LAST_DEC &&
                             cur_year_reg > MIN_YEAR && rem_reg >= ylen)
                    begin
                        // From 31 December a whole year moves back in one step.
                        rem_next      = rem_reg - ylen;
                        cur_year_next = cur_year_reg - 1'b1;
                        state_next    = S_LEAP;
                    end
                    else if (cur_month_reg == MONTH_JAN)
                    begin
                        if (cur_year_reg == MIN_YEAR)
                        begin
                            // Before the first day of year 1: clamp there.
                            cur_day_next = DAY_FIRST;
                            limit_next   = 1'b1;
                            done_next    = 1'b1;
                            state_next   = S_IDLE;
                        end
                        else
                        begin
                            rem_next       = rem_reg - day_cnt;
                            cur_day_next   = DAY_LAST_DEC;
                            cur_month_next = MONTH_DEC;
                            cur_year_next  = cur_year_reg - 1'b1;
                            state_next     = S_LEAP;
                        end
                    end
                    else
                    begin
                        rem_next       = rem_reg - day_cnt;
                        cur_day_next   = prev_mlen;
                        cur_month_next = cur_month_reg - 1'b1;
                    end
                end
            end

            S_LEAP:
            begin
                leap_next  = year_leap;
                state_next = S_STEP;
            end

            S_CMPA:
            begin
                state_next = S_CMPB;
            end

            S_CMPB:
            begin
                state_next = S_CMPC;
            end

            S_CMPC:
            begin
                // The stored date's day number leaves the pipeline now.
                na_next    = dn_number;
                state_next = S_CMPD;
            end

            S_CMPD:
            begin
                if (gvalid_reg && cur_valid)
                begin
                    between_next = (day_gap > NUM_W'(DIST_MAX)) ? DIST_MAX :
                                   day_gap[DIST_W-1:0];
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            done_reg      <= 1'b0;
            cur_day_reg   <= DAY_FIRST;
            cur_month_reg <= MONTH_JAN;
            cur_year_reg  <= 14'd2000;
            leap_reg      <= 1'b1;
            cmd_reg       <= CMD_LOAD;
            relation_reg  <= REL_EQUAL;
            between_reg   <= '0;
            limit_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            cur_day_reg   <= cur_day_next;
            cur_month_reg <= cur_month_next;
            cur_year_reg  <= cur_year_next;
            leap_reg      <= leap_next;
            cmd_reg       <= cmd_next;
            relation_reg  <= relation_next;
            between_reg   <= between_next;
            limit_reg     <= limit_next;
        end
    end

    // Working data of the running command needs no reset.
    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        gdate_reg  <= gdate_next;
        gvalid_reg <= gvalid_next;
        na_reg     <= na_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign day_out      = cur_day_reg;
    assign month_out    = cur_month_reg;
    assign year_out     = cur_year_reg;
    assign date_valid   = cur_valid;
    assign relation     = relation_reg;
    assign days_between = between_reg;
    assign limit_hit    = limit_reg;

`ifndef SYNTHESIS
    // A result beat never overlaps a running command.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // A load answers in the very next cycle.
    a_load_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command == CMD_LOAD) |=> done)
        else $error("load did not finish in one cycle");

    // A compare runs the fixed pipeline sequence.
    a_cmp_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command == CMD_COMPARE) |=> ##4 done)
        else $error("compare latency wrong");

    // Stepping only ever walks through real dates with a current leap flag.
    a_step_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STEP) |-> cur_valid)
        else $error("stepper left the calendar");

    // A clamped step lands on one of the two range boundaries.
    a_limit_edge: assert property (@(posedge clk) disable iff (!rst_n)
        (done && limit_hit) |->
            ((year_out == MAX_YEAR && month_out == MONTH_DEC && day_out == DAY_LAST_DEC) ||
             (year_out == MIN_YEAR && month_out == MONTH_JAN && day_out == DAY_FIRST)))
        else $error("limit flag away from boundary");
`endif

endmodule

// ===== hw/rtl/cds_daynum.sv =====
`timescale 1ns / 1ps

// Two-stage pipeline that turns a valid date into its day number,
// counting 1 January of year 1 as day 0.
module cds_daynum import cds_pkg::*;
(
    input  logic             clk,
    input  date_t            date,
    output logic [NUM_W-1:0] number
);

    logic [YEAR_W-1:0] p;
    logic [YEAR_W-1:0] p_reg;
    logic [NUM_W-1:0]  p365_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [DOY_W-1:0]  doy_reg;
    logic              late_reg;
    logic [NUM_W-1:0]  number_reg;

    logic [QUOT_W-1:0] q100;
    logic [PROD_W-1:0] prod_y;
    logic              leap;

    assign p = date.year - 1'b1;

    always_ff @(posedge clk)
    begin
        p_reg    <= p;
        p365_reg <= NUM_W'(p) * NUM_W'(YEAR_LEN);
        prod_reg <= PROD_W'(p) * PROD_W'(RECIP100);
        doy_reg  <= cum_days(date.month) + DOY_W'(date.day) - DOY_W'(1);
        late_reg <= date.month > MONTH_FEB;
    end

    // The product for the year itself is the one for year - 1 plus one step.
    assign q100   = prod_reg[PROD_W-1:FRAC_W];
    assign prod_y = prod_reg + PROD_W'(RECIP100);
    assign leap   = leap_from_prod(p_reg + 1'b1, prod_y);

    always_ff @(posedge clk)
    begin
        number_reg <= p365_reg + NUM_W'(p_reg[YEAR_W-1:2]) - NUM_W'(q100)
                      + NUM_W'(q100[QUOT_W-1:2]) + NUM_W'(doy_reg)
                      + NUM_W'(leap && late_reg);
    end

    assign number = number_reg;

endmodule
